>>> sv/crc8t_pkg.sv
// shared constants and types of the crc-8 telemetry frame receiver
package crc8t_pkg;

  // default number of 16-bit words in one frame
  localparam int FIELD_COUNT_DEF = 15;

  // crc-8 start value
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // register reset values
  localparam logic [7:0]  CRC_POLY_RST   = 8'h31;
  localparam logic [15:0] JUMP_LIMIT_RST = 16'd50;

  // configuration register indexes
  localparam logic REG_CRC_POLY   = 1'b0;
  localparam logic REG_JUMP_LIMIT = 1'b1;

  // frame status codes
  localparam logic [1:0] STAT_ACCEPT  = 2'd0;
  localparam logic [1:0] STAT_CRC_ERR = 2'd1;
  localparam logic [1:0] STAT_JUMP    = 2'd2;

  // command to the bit-serial crc unit
  typedef struct packed {
    logic       load;
    logic       restart;
    logic [7:0] data;
  } crc_ctrl_t;

endpackage

>>> sv/crc8t_crc_serial.sv
// bit-serial msb-first crc-8 unit, one polynomial step per cycle
module crc8t_crc_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crc8t_pkg::crc_ctrl_t ctrl,
  input  logic [7:0]           poly,
  output logic                 busy,
  output logic [7:0]           crc
);

  logic [7:0] crc_r, crc_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;

  always_comb begin
    crc_nxt  = crc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctrl.load) begin
      crc_nxt  = (ctrl.restart ? crc8t_pkg::CRC_INIT : crc_r) ^ ctrl.data;
      cnt_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = crc_r[7] ? ({crc_r[6:0], 1'b0} ^ poly) : {crc_r[6:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= crc8t_pkg::CRC_INIT;
      cnt_r  <= 3'd0;
      busy_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign crc  = crc_r;

endmodule

>>> sv/crc8t_frame_store.sv
// frame byte memory, one write and one registered read per cycle
module crc8t_frame_store #(
  parameter int DEPTH = 2 * crc8t_pkg::FIELD_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/crc8_telemetry_frame_receiver.sv
// top level of the crc-8 checked telemetry frame receiver
//
// Collects a frame of 2*FIELD_COUNT data bytes and one crc byte from a byte
// stream; a byte with burst_start set always restarts the frame as byte 0.
// Data bytes go into a small frame memory and through a bit-serial crc-8
// (msb first, init 0xFF, programmable polynomial); the serial crc unit takes
// one polynomial step per cycle, so every data byte holds the input for
// its accept and 8 shift steps. Bytes outside a frame are dropped.
// On the crc byte a mismatching or zero crc gives one error item.
// Otherwise the voltage word is read back from the memory (one byte per cycle
// through the registered read port) and compared with the previous voltage;
// then come either one jump item or FIELD_COUNT field items (each field
// item: two memory reads, assemble, hand to the output register), so a good
// frame's crc byte holds the input until its items are emitted, plus any
// output stall. The output register lets the next byte in while the last
// item of a frame still waits to be taken. field_value is the raw signed
// word; scaling to volts is up to the consumer.
module crc8_telemetry_frame_receiver #(
  parameter int FIELD_COUNT = crc8t_pkg::FIELD_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_burst_start,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_frame_status,
  output logic [3:0]         out_field_index,
  output logic signed [15:0] out_field_value,
  output logic               out_last_of_frame,
  // register writes
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int DATA_BYTES_I = 2 * FIELD_COUNT;
  localparam int POS_W  = $clog2(DATA_BYTES_I + 2);
  localparam int ADDR_W = $clog2(DATA_BYTES_I);
  localparam int IDX_W  = $clog2(FIELD_COUNT + 1);
  localparam logic [POS_W-1:0] DATA_BYTES = POS_W'(DATA_BYTES_I);
  localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(DATA_BYTES_I + 1);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FIELD_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_GOT,
    S_CMP,
    S_EMIT
  } state_t;

  // configuration registers
  logic [7:0]  poly_r;
  logic [15:0] limit_r;

  // sequencer state
  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              check_r, check_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [15:0]       v_r, v_nxt;
  logic [16:0]       diff_r, diff_nxt;
  logic [15:0]       prev_r, prev_nxt;

  // pending item
  logic [1:0]        pend_status_r, pend_status_nxt;
  logic [3:0]        pend_idx_r, pend_idx_nxt;
  logic [15:0]       pend_val_r, pend_val_nxt;
  logic              pend_last_r, pend_last_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [3:0]        out_idx_r, out_idx_nxt;
  logic [15:0]       out_val_r, out_val_nxt;
  logic              out_last_r, out_last_nxt;

  // submodule wiring
  crc8t_pkg::crc_ctrl_t crc_ctrl;
  logic                 crc_busy;
  logic [7:0]           crc_val;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [7:0]           mem_rdata;

  // helpers
  logic              accept;
  logic [POS_W-1:0]  pos_eff;
  logic [15:0]       word;
  logic [16:0]       mag;
  logic              out_free;

  crc8t_crc_serial u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .poly  (poly_r),
    .busy  (crc_busy),
    .crc   (crc_val)
  );

  crc8t_frame_store #(
    .DEPTH (DATA_BYTES_I)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_rx_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // input only while the sequencer rests and the crc unit is done
  assign in_ready = (state_r == S_IDLE) && !crc_busy;
  assign accept   = in_valid && in_ready;
  assign pos_eff  = in_burst_start ? '0 : pos_r;

  // little-endian word: high byte arrives from memory while low is held
  assign word     = {mem_rdata, lo_r};
  // magnitude of the 17-bit voltage difference
  assign mag      = diff_r[16] ? (17'd0 - diff_r) : diff_r;
  // output register can take a new item this cycle
  assign out_free = !out_valid_r || out_ready;

  assign mem_waddr = pos_eff[ADDR_W-1:0];

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    idx_nxt         = idx_r;
    check_nxt       = check_r;
    lo_nxt          = lo_r;
    v_nxt           = v_r;
    diff_nxt        = diff_r;
    prev_nxt        = prev_r;
    pend_status_nxt = pend_status_r;
    pend_idx_nxt    = pend_idx_r;
    pend_val_nxt    = pend_val_r;
    pend_last_nxt   = pend_last_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_idx_nxt     = out_idx_r;
    out_val_nxt     = out_val_r;
    out_last_nxt    = out_last_r;
    crc_ctrl.load    = 1'b0;
    crc_ctrl.restart = in_burst_start;
    crc_ctrl.data    = in_rx_byte;
    mem_we          = 1'b0;
    mem_raddr       = ADDR_W'({idx_r, 1'b0});

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (pos_eff < DATA_BYTES) begin
            // data byte: store and fold into the crc
            mem_we        = 1'b1;
            crc_ctrl.load = 1'b1;
            pos_nxt       = pos_eff + POS_W'(1);
          end else if (pos_eff == DATA_BYTES) begin
            // crc byte: judge the frame
            pos_nxt = POS_IDLE;
            if (in_rx_byte != crc_val || in_rx_byte == 8'd0) begin
              pend_status_nxt = crc8t_pkg::STAT_CRC_ERR;
              pend_idx_nxt    = 4'd0;
              pend_val_nxt    = 16'd0;
              pend_last_nxt   = 1'b1;
              state_nxt       = S_EMIT;
            end else begin
              idx_nxt   = '0;
              check_nxt = 1'b1;
              state_nxt = S_RD_LO;
            end
          end
          // bytes past the frame are dropped
        end
      end
      S_RD_LO: begin
        mem_raddr = ADDR_W'({idx_r, 1'b0});
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        mem_raddr = ADDR_W'({idx_r, 1'b1});
        lo_nxt    = mem_rdata;
        state_nxt = S_GOT;
      end
      S_GOT: begin
        if (check_r) begin
          v_nxt     = word;
          diff_nxt  = {word[15], word} - {prev_r[15], prev_r};
          state_nxt = S_CMP;
        end else begin
          pend_status_nxt = crc8t_pkg::STAT_ACCEPT;
          pend_idx_nxt    = 4'(idx_r);
          pend_val_nxt    = word;
          pend_last_nxt   = (idx_r == IDX_LAST);
          state_nxt       = S_EMIT;
        end
      end
      S_CMP: begin
        prev_nxt = v_r;
        if (mag > {1'b0, limit_r}) begin
          pend_status_nxt = crc8t_pkg::STAT_JUMP;
          pend_idx_nxt    = 4'd0;
          pend_val_nxt    = v_r;
          pend_last_nxt   = 1'b1;
          state_nxt       = S_EMIT;
        end else begin
          // voltage ok: stream out every word
          check_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_RD_LO;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_status_r;
          out_idx_nxt    = pend_idx_r;
          out_val_nxt    = pend_val_r;
          out_last_nxt   = pend_last_r;
          if (pend_last_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_RD_LO;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= POS_IDLE;
      idx_r       <= '0;
      check_r     <= 1'b0;
      prev_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      check_r     <= check_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r          <= lo_nxt;
    v_r           <= v_nxt;
    diff_r        <= diff_nxt;
    pend_status_r <= pend_status_nxt;
    pend_idx_r    <= pend_idx_nxt;
    pend_val_r    <= pend_val_nxt;
    pend_last_r   <= pend_last_nxt;
    out_status_r  <= out_status_nxt;
    out_idx_r     <= out_idx_nxt;
    out_val_r     <= out_val_nxt;
    out_last_r    <= out_last_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= crc8t_pkg::CRC_POLY_RST;
      limit_r <= crc8t_pkg::JUMP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        crc8t_pkg::REG_CRC_POLY:   poly_r  <= cfg_wdata[7:0];
        crc8t_pkg::REG_JUMP_LIMIT: limit_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_status  = out_status_r;
  assign out_field_index   = out_idx_r;
  assign out_field_value   = out_val_r;
  assign out_last_of_frame = out_last_r;

endmodule
